// ===== rtl/core/nst_pkg.sv =====
// Shared types, constants and helpers for the name set table.
package nst_pkg;

  localparam int CAPACITY   = 64;
  localparam int NAME_BYTES = 16;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int KEY_W      = 64;
  localparam int CMD_W      = 3;
  localparam int SLOT_W     = 6;
  localparam int STAT_W     = 2;
  localparam int ENT_W      = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_QUERY  = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_INVAL    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_ACT
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] hi;
    logic [KEY_W-1:0] lo;
  } key_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic              by_slot;
    key_t              key;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  fill;
    logic              append_en;
    logic              shift_en;
  } cell_ctl_t;

  // Keep bytes up to the first zero byte and below NAME_BYTES; zero the rest.
  function automatic key_t normalize(logic [KEY_W-1:0] lo, logic [KEY_W-1:0] hi);
    key_t     k;
    logic     keep;
    logic [7:0] b;
    k    = '0;
    keep = 1'b1;
    for (int i = 0; i < 16; i++) begin
      b    = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
      keep = keep && (b != 8'd0) && (i < NAME_BYTES);
      if (keep) begin
        if (i < 8) k.lo[8*i +: 8] = b;
        else       k.hi[8*(i-8) +: 8] = b;
      end
    end
    return k;
  endfunction

endpackage

// ===== rtl/core/nst_if.sv =====
// Valid/ready channel interfaces for commands and results of the name set table.
interface nst_in_if import nst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [KEY_W-1:0]  key_lo;
  logic [KEY_W-1:0]  key_hi;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, cmd, key_lo, key_hi, slot, input ready);
  modport sink   (input valid, cmd, key_lo, key_hi, slot, output ready);
endinterface

interface nst_out_if import nst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              found;
  logic [ENT_W-1:0]  entries;
  logic [KEY_W-1:0]  name_lo;
  logic [KEY_W-1:0]  name_hi;

  modport source (output valid, status, found, entries, name_lo, name_hi, input ready);
  modport sink   (input valid, status, found, entries, name_lo, name_hi, output ready);
endinterface

// ===== rtl/core/nst_cell.sv =====
// One table entry: holds a key, compares it, appends or takes its upper neighbor.
module nst_cell import nst_pkg::*; (
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic [IDX_W-1:0] idx_i,
  input  key_t             nxt_i,
  input  logic             shift_i,
  output logic             hit_o,
  output key_t             key_o
);

  key_t key_q, key_d;
  logic live;
  logic at_fill;

  assign live    = CNT_W'(idx_i) < ctl_i.fill;
  assign at_fill = CNT_W'(idx_i) == ctl_i.fill;

  always_comb begin
    if (ctl_i.by_slot) begin
      hit_o = live && (CNT_W'(idx_i) == CNT_W'(ctl_i.slot));
    end else begin
      hit_o = live && (key_q == ctl_i.key);
    end
  end

  always_comb begin
    key_d = key_q;
    if (ctl_i.append_en && at_fill) begin
      key_d = ctl_i.key;
    end else if (ctl_i.shift_en && shift_i) begin
      key_d = nxt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

// ===== rtl/core/nst_row.sv =====
// Row of table cells with the neighbor shift chain and the one-hot entry select.
module nst_row import nst_pkg::*; (
  input  logic                clk_i,
  input  cell_ctl_t           ctl_i,
  input  logic [CAPACITY-1:0] shift_i,
  input  logic [CAPACITY-1:0] sel_i,
  output logic [CAPACITY-1:0] hit_o,
  output key_t                sel_key_o
);

  key_t keys [CAPACITY];
  key_t nxt  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_last
      assign nxt[i] = '0;
    end else begin : g_mid
      assign nxt[i] = keys[i+1];
    end

    nst_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_i),
      .idx_i   (IDX_W'(i)),
      .nxt_i   (nxt[i]),
      .shift_i (shift_i[i]),
      .hit_o   (hit_o[i]),
      .key_o   (keys[i])
    );
  end

  // Select is one-hot or empty, so an AND-OR picks the entry.
  always_comb begin
    sel_key_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_key_o = sel_key_o | (sel_i[i] ? keys[i] : key_t'('0));
    end
  end

endmodule

// ===== rtl/core/name_set_table_top.sv =====
// Name set table: a row of key cells kept in insertion order, one command per transaction.
// Each accepted command passes through the compare and act states before its result is valid:
// the key is normalized and captured at the accepting edge, then in S_CMP every cell of the row
// compares against it in parallel, and S_ACT acts on the registered hit vector (append at the
// fill position, shift the cells above a removed entry down by one, or pick a slot) and loads
// the result. A new command is taken only in S_IDLE, once the last one has left S_ACT; a result
// left waiting on the output holds the update of the following command until it is taken.
module name_set_table_top import nst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  nst_in_if.sink    req_i,
  nst_out_if.source rsp_o
);

  state_e state_q, state_d;

  cmd_e              cmd_q;
  key_t              key_q;
  logic [SLOT_W-1:0] slot_q;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CAPACITY-1:0] hit_q;
  logic [CAPACITY-1:0] hit;
  logic [CAPACITY-1:0] shift_mask;
  key_t              sel_key;
  logic              any_hit;
  logic              empty;
  logic              fire;

  cell_ctl_t ctl;

  logic              out_valid_q;
  status_e           status_q, status_d;
  logic              found_q, found_d;
  key_t              name_q, name_d;
  logic              append_en, shift_en;

  assign req_i.ready = (state_q == S_IDLE);
  assign fire        = (state_q == S_ACT) && (!out_valid_q || rsp_o.ready);
  assign any_hit     = |hit_q;
  assign empty       = (key_q.lo[7:0] == 8'd0);
  // Cells at and above the removed entry take their upper neighbor.
  assign shift_mask  = ~(hit_q - CAPACITY'(1));

  always_comb begin
    ctl           = '0;
    ctl.by_slot   = (cmd_q == CMD_READ);
    ctl.key       = key_q;
    ctl.slot      = slot_q;
    ctl.fill      = fill_q;
    ctl.append_en = append_en;
    ctl.shift_en  = shift_en;
  end

  nst_row u_row (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .shift_i   (shift_mask),
    .sel_i     (hit_q),
    .hit_o     (hit),
    .sel_key_o (sel_key)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (req_i.valid) state_d = S_CMP;
      S_CMP:   state_d = S_ACT;
      S_ACT:   if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Command outcome and table update.
  always_comb begin
    status_d  = ST_OK;
    found_d   = 1'b0;
    name_d    = '0;
    fill_d    = fill_q;
    append_en = 1'b0;
    shift_en  = 1'b0;
    unique case (cmd_q)
      CMD_ADD: begin
        if (empty) begin
          status_d = ST_INVAL;
        end else if (any_hit) begin
          found_d = 1'b1;
        end else if (fill_q == CNT_W'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          append_en = fire;
          fill_d    = fill_q + CNT_W'(1);
        end
      end
      CMD_QUERY: begin
        found_d = any_hit && !empty;
      end
      CMD_REMOVE: begin
        if (!any_hit || empty) begin
          status_d = ST_NOTFOUND;
        end else begin
          found_d  = 1'b1;
          shift_en = fire;
          fill_d   = fill_q - CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (any_hit) begin
          name_d = sel_key;
        end else begin
          status_d = ST_INVAL;
        end
      end
      CMD_CLEAR: begin
        fill_d = '0;
      end
      default: begin
        status_d = ST_INVAL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      cmd_q  <= cmd_e'(req_i.cmd);
      key_q  <= normalize(req_i.key_lo, req_i.key_hi);
      slot_q <= req_i.slot;
    end
    if (state_q == S_CMP) begin
      hit_q <= hit;
    end
    if (fire) begin
      status_q <= status_d;
      found_q  <= found_d;
      name_q   <= name_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.status  = status_q;
  assign rsp_o.found   = found_q;
  assign rsp_o.entries = ENT_W'(fill_q);
  assign rsp_o.name_lo = name_q.lo;
  assign rsp_o.name_hi = name_q.hi;

endmodule

// ===== rtl/core/nst_checker.sv =====
// Port-level checks for the name set table, bound to the top level.
module nst_checker import nst_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [STAT_W-1:0] status_i,
  input logic              found_i,
  input logic [ENT_W-1:0]  entries_i,
  input logic [KEY_W-1:0]  name_lo_i,
  input logic [KEY_W-1:0]  name_hi_i
);

  // Entry count never exceeds capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (32'(entries_i) <= 32'(CAPACITY)))
    else $error("entry count above capacity");

  // Full is reported only for a new key against a full table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i == ST_FULL) |-> (32'(entries_i) == 32'(CAPACITY) && !found_i))
    else $error("full status with room or with a present key");

  // A failed command returns no name.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i != ST_OK) |-> (name_lo_i == '0 && name_hi_i == '0))
    else $error("name returned with an error status");

  // Hold off the next transaction while the current one is in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("command accepted while busy");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(status_i) &&
      $stable(found_i) && $stable(entries_i) && $stable(name_lo_i) && $stable(name_hi_i)))
    else $error("result changed while stalled");

endmodule

bind name_set_table_top nst_checker u_nst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .found_i     (rsp_o.found),
  .entries_i   (rsp_o.entries),
  .name_lo_i   (rsp_o.name_lo),
  .name_hi_i   (rsp_o.name_hi)
);
